// File: hw/rtl/wmcp_pkg.sv
// ----------------------------------------------------------------------------
// wmcp_pkg: shared types and constants of the min/max column plotter
// Field widths, register indexes and fixed-point constants of the log scale.
// ----------------------------------------------------------------------------
package wmcp_pkg;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int VAL_W      = SAMPLE_W + 1;   // min/max hold +1.0 as well
	localparam int CIDX_W     = 12;
	localparam int Y_W        = 17;
	localparam int TOTAL_W    = 24;
	localparam int COLS_W     = 13;
	localparam int HEIGHT_W   = 13;
	localparam int ROM_W      = 17;             // unsigned Q1.16, up to 1.0
	localparam int L_W        = 18;             // signed Q1.16 log value

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SAMPLES = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLOT_HEIGHT   = 2'd2;

	localparam logic [TOTAL_W-1:0]  TOTAL_RESET  = 24'd1;
	localparam logic [COLS_W-1:0]   COLS_RESET   = 13'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd256;

	// Fixed-point constants
	localparam int ABS_FULL = 32768;            // |x| of full scale, Q0.15
	localparam logic signed [VAL_W-1:0] VAL_POS_FULL = 17'sd32768;
	localparam logic signed [VAL_W-1:0] VAL_NEG_FULL = -17'sd32768;
	localparam int ONE_Q16  = 65536;
	localparam int Y_ROUND  = 4096;
	localparam int Y_SHIFT  = 13;
	localparam int Y_LIMIT  = 131071;

endpackage

// File: hw/rtl/wmcp_sample_if.sv
// ----------------------------------------------------------------------------
// wmcp_sample_if: audio sample channel
// Valid/ready channel carrying one signed Q1.15 sample per transaction.
// ----------------------------------------------------------------------------
interface wmcp_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [wmcp_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/wmcp_column_if.sv
// ----------------------------------------------------------------------------
// wmcp_column_if: plot column channel
// Valid/ready channel carrying the y positions of one closed pixel column.
// ----------------------------------------------------------------------------
interface wmcp_column_if;
	logic                            valid;
	logic                            ready;
	logic [wmcp_pkg::CIDX_W-1:0]     column_index;
	logic [wmcp_pkg::Y_W-1:0]        y_of_min;
	logic [wmcp_pkg::Y_W-1:0]        y_of_max;
	logic                            frame_end;

	modport source (output valid, output column_index, output y_of_min, output y_of_max,
		output frame_end, input ready);
	modport sink   (input valid, input column_index, input y_of_min, input y_of_max,
		input frame_end, output ready);
endinterface

// File: hw/rtl/wmcp_div.sv
// ----------------------------------------------------------------------------
// wmcp_div: column step divider
// Restoring divider, one quotient bit per cycle; done pulses once at the end.
// ----------------------------------------------------------------------------
module wmcp_div #(
	parameter int DIVIDEND_W = 24,
	parameter int DIVISOR_W  = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/wmcp_slog.sv
// ----------------------------------------------------------------------------
// wmcp_slog: signed log2(1+|x|) mapper
// Two-stage pipe: dual-read log ROM, then linear interpolation and sign.
// ----------------------------------------------------------------------------
module wmcp_slog #(
	parameter int TABLE_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  en_a,
	input  logic                                  en_b,
	input  logic signed [wmcp_pkg::VAL_W-1:0]     x,
	output logic signed [wmcp_pkg::L_W-1:0]       l
);

	localparam int SH     = 15 - TABLE_BITS;
	localparam int FULL   = 1 << TABLE_BITS;
	localparam int DEPTH  = FULL + 1;
	localparam int AW     = TABLE_BITS + 1;
	localparam int HALF   = 1 << (SH - 1);
	localparam int PROD_W = wmcp_pkg::ROM_W + SH;

	typedef logic [wmcp_pkg::ROM_W-1:0] rom_t [DEPTH];

	// log2(1 + k/2^B) by bitwise squaring to 18 fraction bits, rounded to 16
	function automatic logic [wmcp_pkg::ROM_W-1:0] rom_entry(input int unsigned k);
		longint unsigned m;
		int unsigned     y;
		y = 0;
		if (k >= FULL) begin
			return wmcp_pkg::ROM_W'(wmcp_pkg::ONE_Q16);
		end
		m = longint'(FULL + k) << (30 - TABLE_BITS);
		for (int i = 1; i <= 18; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				y = y | (32'd1 << (18 - i));
			end
		end
		return wmcp_pkg::ROM_W'((y + 32'd2) >> 2);
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k < DEPTH; k++) begin
			r[k] = rom_entry(k);
		end
		return r;
	endfunction

	localparam rom_t LOG_ROM = build_rom();

	logic                               neg;
	logic [wmcp_pkg::VAL_W-1:0]         mag;
	logic [wmcp_pkg::SAMPLE_W-1:0]      a;
	logic [AW-1:0]                      addr_lo;
	logic [AW-1:0]                      addr_hi;

	logic [wmcp_pkg::ROM_W-1:0]         lo_s2;
	logic [wmcp_pkg::ROM_W-1:0]         hi_s2;
	logic [SH-1:0]                      frac_s2;
	logic                               neg_s2;

	logic [wmcp_pkg::ROM_W-1:0]         diff;
	logic [PROD_W-1:0]                  prod;
	logic [PROD_W:0]                    rnd;
	logic [wmcp_pkg::L_W-1:0]           mag_l;
	logic signed [wmcp_pkg::L_W-1:0]    l_s3;

	// magnitude, clamped to full scale
	assign neg     = x[wmcp_pkg::VAL_W-1];
	assign mag     = neg ? wmcp_pkg::VAL_W'(-x) : wmcp_pkg::VAL_W'(x);
	assign a       = (mag > wmcp_pkg::VAL_W'(wmcp_pkg::ABS_FULL))
		? wmcp_pkg::SAMPLE_W'(wmcp_pkg::ABS_FULL) : mag[wmcp_pkg::SAMPLE_W-1:0];
	assign addr_lo = a[wmcp_pkg::SAMPLE_W-1:SH];
	assign addr_hi = (addr_lo == AW'(FULL)) ? addr_lo : addr_lo + AW'(1);

	always_ff @(posedge clk) begin
		if (en_a) begin
			lo_s2   <= LOG_ROM[addr_lo];
			hi_s2   <= LOG_ROM[addr_hi];
			frac_s2 <= a[SH-1:0];
			neg_s2  <= neg;
		end
	end

	// interpolate between neighbors, round half up
	assign diff  = hi_s2 - lo_s2;
	assign prod  = PROD_W'(diff) * PROD_W'(frac_s2);
	assign rnd   = {1'b0, prod} + (PROD_W + 1)'(HALF);
	assign mag_l = {1'b0, lo_s2} + rnd[PROD_W:SH];

	always_ff @(posedge clk) begin
		if (en_b) begin
			l_s3 <= neg_s2 ? -$signed(mag_l) : $signed(mag_l);
		end
	end

	assign l = l_s3;

endmodule

// File: hw/rtl/waveform_minmax_column_plotter.sv
// ----------------------------------------------------------------------------
// waveform_minmax_column_plotter: min/max column reducer with log vertical scale
// Path: a closing sample's column reaches plot through stages s1 to s4 below.
// Throughput: one sample per cycle unless stalled; at most one column per sample.
// Reset and every register write restart the frame and stall audio during the divide.
// ----------------------------------------------------------------------------
//
// Column boundaries: the step N/W is found once per configuration by a bit-serial
// divider (24 steps, one quotient bit per cycle). From then on, the start of the
// next column and the last sample of the current one advance by add-and-compare
// on a quotient/remainder pair, so the per-sample work is compares and adds.
//
// Pipeline behind the sample transaction:
//   s1  closed column: index, min, max, frame end
//   s2  log ROM read (two entries per value, min and max mapped in parallel)
//   s3  interpolation and sign
//   s4  y = (1 - l) * height * 8 with rounding and saturation; drives plot
// Each stage loads when it is empty or its content moves on, so bubbles collapse;
// samples stall only during the divide or when all four stages wait on plot.
module waveform_minmax_column_plotter #(
	parameter int MAX_COLUMNS    = 4096,
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	wmcp_sample_if.sink                         audio,
	wmcp_column_if.source                       plot,
	input  logic                                cfg_we,
	input  logic [wmcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wmcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int WCNT_W = $clog2(MAX_COLUMNS + 1);    // holds the column count
	localparam int CNT_W  = $clog2(MAX_COLUMNS);        // holds a column number
	localparam int EXT_W  = (CNT_W > wmcp_pkg::CIDX_W) ? CNT_W : wmcp_pkg::CIDX_W;
	localparam int TW     = wmcp_pkg::TOTAL_W;
	localparam logic [TW-1:0] MAX_COLS_T = TW'(MAX_COLUMNS);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [TW-1:0]                    total_q;
	logic [wmcp_pkg::COLS_W-1:0]      columns_q;
	logic [wmcp_pkg::HEIGHT_W-1:0]    height_q;
	logic                             cfg_hit;

	assign cfg_hit = cfg_we && ((cfg_index == wmcp_pkg::REG_TOTAL_SAMPLES)
		|| (cfg_index == wmcp_pkg::REG_COLUMNS)
		|| (cfg_index == wmcp_pkg::REG_PLOT_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= wmcp_pkg::TOTAL_RESET;
			columns_q <= wmcp_pkg::COLS_RESET;
			height_q  <= wmcp_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wmcp_pkg::REG_TOTAL_SAMPLES: total_q   <= cfg_data[TW-1:0];
				wmcp_pkg::REG_COLUMNS:       columns_q <= cfg_data[wmcp_pkg::COLS_W-1:0];
				wmcp_pkg::REG_PLOT_HEIGHT:   height_q  <= cfg_data[wmcp_pkg::HEIGHT_W-1:0];
				default: ;  // indexes past the register list are dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Effective N and W, and the step N/W
	// ------------------------------------------------------------------
	logic [TW-1:0]      n_eff;
	logic [TW-1:0]      c_eff;
	logic [TW-1:0]      c_cap;
	logic [TW-1:0]      w_t;
	logic [WCNT_W-1:0]  w_comb;

	// zero counts mean one; W is capped by the column limit, then by N
	assign n_eff  = (total_q == '0) ? TW'(1) : total_q;
	assign c_eff  = (columns_q == '0) ? TW'(1) : TW'(columns_q);
	assign c_cap  = (c_eff > MAX_COLS_T) ? MAX_COLS_T : c_eff;
	assign w_t    = (c_cap > n_eff) ? n_eff : c_cap;
	assign w_comb = w_t[WCNT_W-1:0];

	logic               kick_q;     // start the divider after reset or a write
	logic               step_ok_q;  // step is known, samples may flow
	logic [WCNT_W-1:0]  w_q;
	logic [CNT_W-1:0]   wm1_q;
	logic               div_done;
	logic               step_done;
	logic [TW-1:0]      step_quo;
	logic [WCNT_W-1:0]  step_rem;

	wmcp_div #(
		.DIVIDEND_W (TW),
		.DIVISOR_W  (WCNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (kick_q),
		.dividend  (n_eff),
		.divisor   (w_comb),
		.done      (div_done),
		.quotient  (step_quo),
		.remainder (step_rem)
	);

	// a done pulse that meets a fresh start belongs to the old settings: drop it
	assign step_done = div_done && !kick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_q    <= 1'b1;
			step_ok_q <= 1'b0;
			w_q       <= '0;
			wm1_q     <= '0;
		end else begin
			kick_q <= cfg_hit;
			if (cfg_hit) begin
				step_ok_q <= 1'b0;
			end else if (step_done) begin
				step_ok_q <= 1'b1;
			end
			if (kick_q) begin
				w_q   <= w_comb;
				wm1_q <= CNT_W'(w_comb - WCNT_W'(1));
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline handshake
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;
	logic acc;

	assign ld4 = !v_s4 || plot.ready;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	// hold samples off while the step is being recomputed
	assign audio.ready = step_ok_q && ld1;
	assign acc         = audio.valid && audio.ready;

	// ------------------------------------------------------------------
	// Frame state: position, column, boundaries, running min/max pairs
	// ------------------------------------------------------------------
	logic [TW-1:0]                          sp_q;       // sample position in frame
	logic [CNT_W-1:0]                       col_q;      // current column
	logic [TW-1:0]                          nq_q;       // first sample of next column
	logic [WCNT_W-1:0]                      nr_q;       // its remainder
	logic [TW-1:0]                          endm1_q;    // last sample of current column
	logic signed [wmcp_pkg::VAL_W-1:0]      cur_min_q, cur_max_q, next_min_q, next_max_q;

	logic signed [wmcp_pkg::VAL_W-1:0]      s_ext;
	logic signed [wmcp_pkg::VAL_W-1:0]      cmin, cmax, nmin, nmax;
	logic                                   has_next, in_next, close;
	logic [TW-1:0]                          start_endm1;
	logic [WCNT_W:0]                        sum_r;
	logic [WCNT_W:0]                        sum_r_wrap;
	logic                                   wrap;
	logic [WCNT_W-1:0]                      nr_next;
	logic [TW-1:0]                          nq_base, nq_next, endm1_next;

	assign s_ext = {audio.sample[wmcp_pkg::SAMPLE_W-1], audio.sample};

	assign has_next = (col_q != wm1_q);
	assign in_next  = has_next && (sp_q >= nq_q);
	assign close    = (sp_q >= endm1_q);

	// fold the sample into both running pairs
	assign cmin = (s_ext < cur_min_q) ? s_ext : cur_min_q;
	assign cmax = (s_ext > cur_max_q) ? s_ext : cur_max_q;
	assign nmin = (in_next && (s_ext < next_min_q)) ? s_ext : next_min_q;
	assign nmax = (in_next && (s_ext > next_max_q)) ? s_ext : next_max_q;

	// first column ends at ceil(N/W) - 1
	assign start_endm1 = (step_rem != '0) ? step_quo : step_quo - TW'(1);

	// advance the boundary by one step; carry the remainder into the quotient
	assign sum_r      = {1'b0, nr_q} + {1'b0, step_rem};
	assign wrap       = (sum_r >= {1'b0, w_q});
	assign sum_r_wrap = sum_r - {1'b0, w_q};
	assign nr_next    = wrap ? sum_r_wrap[WCNT_W-1:0] : sum_r[WCNT_W-1:0];
	assign nq_base    = nq_q + step_quo;
	assign nq_next    = nq_base + TW'(wrap);
	assign endm1_next = (nr_next != '0) ? nq_next : nq_next - TW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q       <= '0;
			col_q      <= '0;
			nq_q       <= '0;
			nr_q       <= '0;
			endm1_q    <= '0;
			cur_min_q  <= wmcp_pkg::VAL_POS_FULL;
			cur_max_q  <= wmcp_pkg::VAL_NEG_FULL;
			next_min_q <= wmcp_pkg::VAL_POS_FULL;
			next_max_q <= wmcp_pkg::VAL_NEG_FULL;
		end else if (cfg_hit) begin
			// restart the frame; boundaries reload when the divider is done
			sp_q       <= '0;
			col_q      <= '0;
			cur_min_q  <= wmcp_pkg::VAL_POS_FULL;
			cur_max_q  <= wmcp_pkg::VAL_NEG_FULL;
			next_min_q <= wmcp_pkg::VAL_POS_FULL;
			next_max_q <= wmcp_pkg::VAL_NEG_FULL;
		end else if (step_done) begin
			nq_q    <= step_quo;
			nr_q    <= step_rem;
			endm1_q <= start_endm1;
		end else if (acc) begin
			if (!close) begin
				sp_q       <= sp_q + TW'(1);
				cur_min_q  <= cmin;
				cur_max_q  <= cmax;
				next_min_q <= nmin;
				next_max_q <= nmax;
			end else if (!has_next) begin
				// last column of the frame: start over
				sp_q       <= '0;
				col_q      <= '0;
				nq_q       <= step_quo;
				nr_q       <= step_rem;
				endm1_q    <= start_endm1;
				cur_min_q  <= wmcp_pkg::VAL_POS_FULL;
				cur_max_q  <= wmcp_pkg::VAL_NEG_FULL;
				next_min_q <= wmcp_pkg::VAL_POS_FULL;
				next_max_q <= wmcp_pkg::VAL_NEG_FULL;
			end else begin
				// hand the next pair over to the current column
				sp_q       <= sp_q + TW'(1);
				col_q      <= col_q + CNT_W'(1);
				nq_q       <= nq_next;
				nr_q       <= nr_next;
				endm1_q    <= endm1_next;
				cur_min_q  <= nmin;
				cur_max_q  <= nmax;
				next_min_q <= wmcp_pkg::VAL_POS_FULL;
				next_max_q <= wmcp_pkg::VAL_NEG_FULL;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result pipeline
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= acc && close;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	logic [EXT_W-1:0]                       col_ext;
	logic [wmcp_pkg::CIDX_W-1:0]            idx_s1, idx_s2, idx_s3, idx_s4;
	logic                                   fe_s1, fe_s2, fe_s3, fe_s4;
	logic signed [wmcp_pkg::VAL_W-1:0]      min_s1, max_s1;
	logic signed [wmcp_pkg::L_W-1:0]        lmin_s3, lmax_s3;
	logic [wmcp_pkg::Y_W-1:0]               ymin_s4, ymax_s4;

	assign col_ext = EXT_W'(col_q);

	always_ff @(posedge clk) begin
		if (ld1) begin
			idx_s1 <= col_ext[wmcp_pkg::CIDX_W-1:0];
			fe_s1  <= !has_next;
			min_s1 <= cmin;
			max_s1 <= cmax;
		end
		if (ld2) begin
			idx_s2 <= idx_s1;
			fe_s2  <= fe_s1;
		end
		if (ld3) begin
			idx_s3 <= idx_s2;
			fe_s3  <= fe_s2;
		end
	end

	wmcp_slog #(
		.TABLE_BITS (LOG_TABLE_BITS)
	) u_slog_min (
		.clk  (clk),
		.en_a (ld2),
		.en_b (ld3),
		.x    (min_s1),
		.l    (lmin_s3)
	);

	wmcp_slog #(
		.TABLE_BITS (LOG_TABLE_BITS)
	) u_slog_max (
		.clk  (clk),
		.en_a (ld2),
		.en_b (ld3),
		.x    (max_s1),
		.l    (lmax_s3)
	);

	// y = ((1.0 - l) * height + half) >> 13, saturated to the field width
	function automatic logic [wmcp_pkg::Y_W-1:0] to_y(
		input logic signed [wmcp_pkg::L_W-1:0] lv,
		input logic [wmcp_pkg::HEIGHT_W-1:0]   h
	);
		logic [wmcp_pkg::L_W:0]                                   d_w;
		logic [wmcp_pkg::L_W-1:0]                                 d;
		logic [wmcp_pkg::L_W+wmcp_pkg::HEIGHT_W-1:0]              t;
		logic [wmcp_pkg::L_W+wmcp_pkg::HEIGHT_W:0]                r;
		logic [wmcp_pkg::L_W+wmcp_pkg::HEIGHT_W-wmcp_pkg::Y_SHIFT:0] q;
		d_w = (wmcp_pkg::L_W + 1)'(wmcp_pkg::ONE_Q16) - {lv[wmcp_pkg::L_W-1], lv};
		d   = d_w[wmcp_pkg::L_W-1:0];
		t   = d * h;
		r   = {1'b0, t} + (wmcp_pkg::L_W + wmcp_pkg::HEIGHT_W + 1)'(wmcp_pkg::Y_ROUND);
		q   = r[wmcp_pkg::L_W+wmcp_pkg::HEIGHT_W:wmcp_pkg::Y_SHIFT];
		if (q > (wmcp_pkg::L_W + wmcp_pkg::HEIGHT_W - wmcp_pkg::Y_SHIFT + 1)'(wmcp_pkg::Y_LIMIT))
		begin
			return wmcp_pkg::Y_W'(wmcp_pkg::Y_LIMIT);
		end
		return q[wmcp_pkg::Y_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (ld4) begin
			idx_s4  <= idx_s3;
			fe_s4   <= fe_s3;
			ymin_s4 <= to_y(lmin_s3, height_q);
			ymax_s4 <= to_y(lmax_s3, height_q);
		end
	end

	assign plot.valid        = v_s4;
	assign plot.column_index = idx_s4;
	assign plot.y_of_min     = ymin_s4;
	assign plot.y_of_max     = ymax_s4;
	assign plot.frame_end    = fe_s4;

endmodule
